@@ rtl/soft_brush_canvas_painter_top_assert.svh @@
// assertion macros for the soft brush canvas painter
`ifndef SOFT_BRUSH_CANVAS_PAINTER_TOP_ASSERT_SVH
`define SOFT_BRUSH_CANVAS_PAINTER_TOP_ASSERT_SVH

// a condition that must hold at every edge out of reset
`define SBCP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// an antecedent implying a consequent in the next cycle
`define SBCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sbcp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcp_pkg
// shared types and constants of the soft brush canvas painter
// ----------------------------------------------------------------------------
`default_nettype none
package sbcp_pkg;
   localparam int GRID_SIZE  = 28;
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COORD_W    = $clog2(GRID_SIZE);

   localparam logic [1:0] KIND_PAINT = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_READ_OUT,
      ST_PIX_RD,
      ST_SQRT,
      ST_DIV,
      ST_WRITE,
      ST_NEXT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture item and radius
      logic clear_step; // write zero at sweep address
      logic clear_init;
      logic rd_pixel;   // issue canvas read of next pixel of the box
      logic sqrt_start;
      logic div_start;
      logic wr_pixel;   // write updated ink
      logic advance;    // step to next pixel of the box
      logic rd_item;    // issue canvas read of item index
      logic rd_capture; // hold the ink of a read beat
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic in_radius;
      logic sqrt_done;
      logic div_done;
      logic box_done;
   } stat_type;
endpackage
`default_nettype wire

@@ rtl/sbcp_ram.sv @@
// ----------------------------------------------------------------------------
// sbcp_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module sbcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 784
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ rtl/sbcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbcp_ctrl
// sequencer for paint, clear and read items
// ----------------------------------------------------------------------------
`default_nettype none
module sbcp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic [1:0]        req_kind,
   input  wire logic              rsp_fire,
   input  wire sbcp_pkg::stat_type stat,
   output sbcp_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import sbcp_pkg::*;

   state_type state_ff, state_in;

   // reset starts a clearing sweep of the canvas
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_PAINT: state_in = ST_PIX_RD;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  KIND_READ:  state_in = ST_READ_WAIT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR:     if (stat.clear_done) state_in = ST_IDLE;
         ST_READ_WAIT: state_in = ST_READ_OUT;
         ST_READ_OUT:  if (rsp_fire) state_in = ST_IDLE;
         ST_PIX_RD:    state_in = stat.in_radius ? ST_SQRT : ST_NEXT;
         ST_SQRT:      if (stat.sqrt_done) state_in = ST_DIV;
         ST_DIV:       if (stat.div_done) state_in = ST_WRITE;
         ST_WRITE:     state_in = ST_NEXT;
         ST_NEXT:      state_in = stat.box_done ? ST_IDLE : ST_PIX_RD;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load = req_fire;
            cmd.clear_init = req_fire;
            cmd.rd_item = req_fire;
         end
         ST_CLEAR:     cmd.clear_step = 1'b1;
         ST_READ_WAIT: cmd.rd_capture = 1'b1;
         ST_READ_OUT:  rsp_valid = 1'b1;
         ST_PIX_RD: begin
            cmd.sqrt_start = stat.in_radius;
         end
         ST_SQRT:  cmd.div_start = stat.sqrt_done;
         ST_WRITE: cmd.wr_pixel = 1'b1;
         ST_NEXT: begin
            cmd.advance = 1'b1;
            cmd.rd_pixel = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/sbcp_datapath.sv @@
// ----------------------------------------------------------------------------
// sbcp_datapath
// canvas memory, box scan, bit serial root and divide
// ----------------------------------------------------------------------------
`default_nettype none
module sbcp_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sbcp_pkg::cmd_type           cmd,
   input  wire logic [3:0]                  radius_halves,
   input  wire logic signed [10:0]          center_x,
   input  wire logic signed [10:0]          center_y,
   input  wire logic [9:0]                  pixel_index,
   output sbcp_pkg::stat_type               stat,
   output logic [7:0]                       pixel_ink,
   output logic [9:0]                       pixel_addr
);
   import sbcp_pkg::*;

   localparam int GMAX = GRID_SIZE - 1;

   logic [6:0] rad_ff;        // R in 1/16 pixel
   logic signed [11:0] cx_ff, cy_ff;
   logic [COORD_W-1:0] x_ff, y_ff, x0_ff, x1_ff, y1_ff;
   logic empty_ff;
   logic [9:0] idx_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] ram_addr;
   logic ram_we;
   logic [7:0] ram_wd, ram_rd;
   logic [7:0] ink_ff;

   // sqrt and divide registers
   logic [23:0] sq_v_ff;
   logic [23:0] sq_res_ff;
   logic [3:0]  sq_cnt_ff;
   logic        sq_busy_ff;
   logic        sq_fin_ff;
   logic [34:0] dv_rem_ff;
   logic [8:0]  dv_q_ff;
   logic [3:0]  dv_cnt_ff;
   logic        dv_busy_ff;
   logic [34:0] dv_den_ff;

   logic [3:0] h;
   assign h = (radius_halves == 4'd0) ? 4'd1 : (radius_halves > 4'd12) ? 4'd12 : radius_halves;

   // box bounds from center and radius, clipped
   function automatic logic signed [12:0] lo_pix(input logic signed [11:0] c,
                                                   input logic [6:0] r);
      logic signed [12:0] t;
      t = 13'(c) - 13'(r) + 13'sd7;  // ceil((c-r-8)/16)
      return t >>> 4;
   endfunction

   function automatic logic signed [12:0] hi_pix(input logic signed [11:0] c,
                                                   input logic [6:0] r);
      logic signed [12:0] t;
      t = 13'(c) + 13'(r) - 13'sd8;
      return t >>> 4;
   endfunction

   logic signed [12:0] bx0, bx1, by0, by1, cx0, cx1, cy0, cy1;
   logic signed [11:0] ncx, ncy;
   logic [6:0] nrad;
   assign ncx = 12'(center_x);
   assign ncy = 12'(center_y);
   assign nrad = {h, 3'b000};
   assign bx0 = lo_pix(ncx, nrad);
   assign bx1 = hi_pix(ncx, nrad);
   assign by0 = lo_pix(ncy, nrad);
   assign by1 = hi_pix(ncy, nrad);
   assign cx0 = (bx0 < 0) ? 13'sd0 : bx0;
   assign cx1 = (bx1 > 13'(GMAX)) ? 13'(GMAX) : bx1;
   assign cy0 = (by0 < 0) ? 13'sd0 : by0;
   assign cy1 = (by1 > 13'(GMAX)) ? 13'(GMAX) : by1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rad_ff <= nrad;
         cx_ff <= ncx;
         cy_ff <= ncy;
         idx_ff <= pixel_index;
         x_ff <= COORD_W'(cx0);
         x0_ff <= COORD_W'(cx0);
         x1_ff <= COORD_W'(cx1);
         y_ff <= COORD_W'(cy0);
         y1_ff <= COORD_W'(cy1);
         empty_ff <= (cx0 > cx1) || (cy0 > cy1);
      end else if (cmd.advance) begin
         if (x_ff == x1_ff) begin
            x_ff <= x0_ff;
            y_ff <= y_ff + 1'b1;
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

   // clear sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_init) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // offsets
   logic signed [12:0] dx, dy;
   logic [25:0] dxx, dyy;
   assign dx = 13'({x_ff, 4'b1000}) - 13'(cx_ff);
   assign dy = 13'({y_ff, 4'b1000}) - 13'(cy_ff);
   assign dxx = 26'(dx * dx);
   assign dyy = 26'(dy * dy);
   logic [26:0] d2;
   assign d2 = 27'(dxx) + 27'(dyy);
   logic [13:0] r2;
   assign r2 = 14'(rad_ff * rad_ff);
   logic inr;
   assign inr = !empty_ff && (d2 <= 27'(r2));

   logic [10:0] rq;
   assign rq = {rad_ff, 4'b0000};
   logic [21:0] rq2;
   assign rq2 = 22'(rq * rq);

   // restoring square root of d2*256, one result bit a cycle
   logic [23:0] sq_bit;
   logic [23:0] sq_trial;
   assign sq_bit = 24'(1) << {sq_cnt_ff, 1'b0};
   assign sq_trial = sq_res_ff + sq_bit;

   logic [11:0] f;
   logic [10:0] d_res;
   assign d_res = sq_res_ff[10:0];
   assign f = (12'(d_res) >= 12'(rq)) ? 12'd0 : 12'(rq) - 12'(d_res);
   logic [23:0] ff2;
   assign ff2 = 24'(f * f);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_fin_ff <= 1'b0;
         dv_busy_ff <= 1'b0;
      end else begin
         sq_fin_ff <= sq_busy_ff && (sq_cnt_ff == 4'd0);
         if (cmd.sqrt_start) begin
            sq_busy_ff <= 1'b1;
         end else if (sq_busy_ff && sq_cnt_ff == 4'd0) begin
            sq_busy_ff <= 1'b0;
         end
         if (cmd.div_start) begin
            dv_busy_ff <= 1'b1;
         end else if (dv_busy_ff && dv_cnt_ff == 4'd0) begin
            dv_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sq_v_ff <= {2'b00, d2[13:0], 8'b0};
         sq_res_ff <= '0;
         sq_cnt_ff <= 4'd11;
      end else if (sq_busy_ff) begin
         if (sq_v_ff >= sq_trial) begin
            sq_v_ff <= sq_v_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
      end
   end

   // restoring divide, quotient fits 9 bits
   logic [34:0] dv_shift;
   assign dv_shift = dv_den_ff << dv_cnt_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         // 255 * f^2 as f^2 * 256 - f^2, plus half the divisor
         dv_rem_ff <= {3'b000, ff2, 8'b0} - 35'(ff2) + 35'(rq2 >> 1);
         dv_den_ff <= 35'(rq2);
         dv_q_ff <= '0;
         dv_cnt_ff <= 4'd8;
      end else if (dv_busy_ff) begin
         if (dv_rem_ff >= dv_shift) begin
            dv_rem_ff <= dv_rem_ff - dv_shift;
            dv_q_ff[dv_cnt_ff] <= 1'b1;
         end
         dv_cnt_ff <= dv_cnt_ff - 1'b1;
      end
   end

   logic [8:0] sum;
   assign sum = 9'(ram_rd) + dv_q_ff;

   logic [ADDR_W-1:0] pix_addr;
   assign pix_addr = ADDR_W'(y_ff * GRID_SIZE) + ADDR_W'(x_ff);
   logic [ADDR_W-1:0] nx_addr;
   logic [COORD_W-1:0] nx, ny;
   assign nx = (x_ff == x1_ff) ? x0_ff : x_ff + 1'b1;
   assign ny = (x_ff == x1_ff) ? y_ff + 1'b1 : y_ff;
   assign nx_addr = ADDR_W'(ny * GRID_SIZE) + ADDR_W'(nx);

   always_comb begin
      ram_we = 1'b0;
      ram_wd = '0;
      ram_addr = pix_addr;
      if (cmd.rd_item) begin
         ram_addr = (pixel_index < 10'(CELL_COUNT)) ? ADDR_W'(pixel_index) : '0;
      end else if (cmd.clear_step) begin
         ram_addr = clr_ff;
         ram_we = 1'b1;
      end else if (cmd.wr_pixel) begin
         ram_we = 1'b1;
         ram_wd = sum[8] ? 8'hFF : sum[7:0];
      end else if (cmd.rd_pixel) begin
         ram_addr = nx_addr;
      end
   end

   sbcp_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   logic rd_ok_ff;
   always_ff @(posedge clock) begin
      if (cmd.rd_item) rd_ok_ff <= pixel_index < 10'(CELL_COUNT);
   end

   // off canvas reads give zero ink
   always_ff @(posedge clock) begin
      if (cmd.rd_capture) ink_ff <= rd_ok_ff ? ram_rd : 8'd0;
   end

   assign pixel_ink = ink_ff;
   assign pixel_addr = idx_ff;

   assign stat.clear_done = (clr_ff == ADDR_W'(CELL_COUNT - 1));
   assign stat.in_radius = inr;
   assign stat.sqrt_done = sq_fin_ff;
   assign stat.div_done = dv_busy_ff && (dv_cnt_ff == 4'd0);
   assign stat.box_done = empty_ff || ((x_ff == x1_ff) && (y_ff == y1_ff));
endmodule
`default_nettype wire

@@ rtl/soft_brush_canvas_painter_top.sv @@
// ----------------------------------------------------------------------------
// soft_brush_canvas_painter_top
// soft brush painter over a square ink canvas
// ----------------------------------------------------------------------------
// A paint beat walks the clipped bounding box of the brush one pixel at a time:
// each box pixel passes a read state and a next state, and each pixel inside the
// radius also passes the bit serial root, the divide and the write between them.
// A clear beat sweeps the canvas one cell a cycle, and the same sweep runs after
// reset, with req_tready low. A read beat passes a wait state and gives its
// registered result in the output state, and the next beat is taken once the
// result has left; the canvas is a single port ram.
`default_nettype none
module soft_brush_canvas_painter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // kind
   input  wire logic [31:0] req_tdata,   // center_x, center_y, pixel_index
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // pixel_ink, pixel_addr
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);
   import sbcp_pkg::*;

   logic [3:0] radius_ff;
   cmd_type cmd;
   stat_type stat;
   logic busy, req_fire, rsp_fire;
   logic [7:0] ink;
   logic [9:0] addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd4;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   sbcp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_kind(req_tuser),
      .rsp_fire(rsp_fire), .stat(stat), .cmd(cmd), .busy(busy), .rsp_valid(rsp_tvalid)
   );

   sbcp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .radius_halves(radius_ff),
      .center_x(req_tdata[10:0]), .center_y(req_tdata[21:11]),
      .pixel_index(req_tdata[31:22]), .stat(stat), .pixel_ink(ink), .pixel_addr(addr)
   );

   assign rsp_tdata = {6'd0, addr, ink};

`include "soft_brush_canvas_painter_top_assert.svh"

   `SBCP_ASSERT_ALWAYS(a_no_accept_busy, clock, reset, !(rsp_tvalid && req_tready), "ready")
   `SBCP_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "dropped")
endmodule
`default_nettype wire
